// ===== hdl/luinv_pkg.sv =====
// ----------------------------------------------------------------------------
// luinv_pkg
// Shared constants, types and fixed-point helpers for the LU matrix inverse.
// ----------------------------------------------------------------------------
package luinv_pkg;

    // Sizing
    localparam int MAX_SIZE  = 8;
    localparam int FRAC_BITS = 16;
    localparam int IDX_W     = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int CNT_W     = $clog2(MAX_SIZE + 1);
    localparam int MAT_DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int MAT_AW    = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;

    // Divider widths: magnitude of the scaled numerator and of the divisor
    localparam int DIV_W  = 63;
    localparam int DEN_W  = 32;
    localparam int DIV_CW = $clog2(DIV_W);

    // Fixed-point constants
    localparam logic [31:0] ONE_FX      = 32'(64'd1 << FRAC_BITS);
    localparam logic [63:0] NUM_LIM     = 64'd1 << (62 - FRAC_BITS);
    localparam logic [DIV_W-1:0] SCALE_NUM = DIV_W'(64'd1 << (2 * FRAC_BITS));
    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    // Register map
    localparam logic REG_MATRIX_SIZE = 1'b0;

    // Divider request and response
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num_mag;
        logic [DEN_W-1:0] den_mag;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
    } div_rsp_t;

    // Saturate a 64-bit sum to 32 bits signed
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX)
            r = 32'sh7FFFFFFF;
        else if (v < S32_MIN)
            r = 32'sh80000000;
        else
            r = $signed(v[31:0]);
        return r;
    endfunction

    // Magnitude of a signed word; the most negative value maps to 2^31
    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic [31:0] r;
        r = v[31] ? 32'(-v) : 32'(v);
        return r;
    endfunction

    // Sign extension to the accumulator width
    function automatic logic signed [63:0] ext64(input logic signed [31:0] v);
        logic signed [63:0] r;
        r = 64'(v);
        return r;
    endfunction

    // Row-major address into the matrix store
    function automatic logic [MAT_AW-1:0] mat_addr(input logic [IDX_W-1:0] row,
                                                   input logic [IDX_W-1:0] col);
        logic [MAT_AW-1:0] r;
        r = MAT_AW'(32'(row) * MAX_SIZE + 32'(col));
        return r;
    endfunction

endpackage

// ===== hdl/luinv_ram.sv =====
// ----------------------------------------------------------------------------
// luinv_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module luinv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/luinv_div.sv =====
// ----------------------------------------------------------------------------
// luinv_div
// Bit-serial restoring divider on magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module luinv_div import luinv_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg;
    logic              done_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DIV_W-1:0]  quo_reg;

    logic [DEN_W:0]    rem_sh;
    logic [DEN_W:0]    rem_sub;
    logic              take;

    // Shift in the next dividend bit and trial-subtract
    assign rem_sh  = {rem_reg, quo_reg[DIV_W-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign take    = (rem_sh >= {1'b0, den_reg});

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CW'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.num_mag;
            den_reg <= req.den_mag;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], take};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;

endmodule

// ===== hdl/lu_pivot_matrix_inverse_core.sv =====
// ----------------------------------------------------------------------------
// lu_pivot_matrix_inverse_core
// Loads an n x n Q16.16 matrix, runs Crout LU with scaled partial pivoting,
// solves each unit column and streams the inverse out column by column.
// ----------------------------------------------------------------------------
// Loading accepts elements row by row; the run starts after the last one.
// The run performs n + n(n-1)/2 + n*n divisions on the bit-serial divider;
// each multiply-add reads its operands, multiplies into the product register
// and then accumulates. Within a column each result is read and then presented,
// and it is held while the output is stalled.
// Reset clears control state; matrix_size returns to 8, stores are not cleared.
module lu_pivot_matrix_inverse_core import luinv_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // element input
    input  logic        in_valid,
    output logic        in_stall,
    input  logic signed [31:0] element_value,
    // result output
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [31:0] inverse_value,
    output logic        status,
    output logic        last_result
);

    localparam int STATE_W = 41;

    typedef enum logic [STATE_W-1:0] {
        ST_LOAD     = STATE_W'(1) << 0,
        ST_SC_RD    = STATE_W'(1) << 1,
        ST_SC_CMP   = STATE_W'(1) << 2,
        ST_SC_DIV   = STATE_W'(1) << 3,
        ST_CL_RD0   = STATE_W'(1) << 4,
        ST_CL_LD0   = STATE_W'(1) << 5,
        ST_CL_RDA   = STATE_W'(1) << 6,
        ST_CL_RDB   = STATE_W'(1) << 7,
        ST_CL_MUL   = STATE_W'(1) << 8,
        ST_CL_ACC   = STATE_W'(1) << 9,
        ST_CL_WR    = STATE_W'(1) << 10,
        ST_CL_SCM   = STATE_W'(1) << 11,
        ST_CL_SCC   = STATE_W'(1) << 12,
        ST_SW_RD1   = STATE_W'(1) << 13,
        ST_SW_RD2   = STATE_W'(1) << 14,
        ST_SW_WR1   = STATE_W'(1) << 15,
        ST_SW_WR2   = STATE_W'(1) << 16,
        ST_PV_RD    = STATE_W'(1) << 17,
        ST_PV_CHK   = STATE_W'(1) << 18,
        ST_DV_RD    = STATE_W'(1) << 19,
        ST_DV_START = STATE_W'(1) << 20,
        ST_DV_WAIT  = STATE_W'(1) << 21,
        ST_CW_INIT  = STATE_W'(1) << 22,
        ST_FW_RD    = STATE_W'(1) << 23,
        ST_FW_RD2   = STATE_W'(1) << 24,
        ST_FW_WR    = STATE_W'(1) << 25,
        ST_FW_RDA   = STATE_W'(1) << 26,
        ST_FW_MUL   = STATE_W'(1) << 27,
        ST_FW_ACC   = STATE_W'(1) << 28,
        ST_FW_ST    = STATE_W'(1) << 29,
        ST_BK_RD    = STATE_W'(1) << 30,
        ST_BK_LD    = STATE_W'(1) << 31,
        ST_BK_RDA   = STATE_W'(1) << 32,
        ST_BK_MUL   = STATE_W'(1) << 33,
        ST_BK_ACC   = STATE_W'(1) << 34,
        ST_BK_DRD   = STATE_W'(1) << 35,
        ST_BK_DST   = STATE_W'(1) << 36,
        ST_BK_DW    = STATE_W'(1) << 37,
        ST_EM_RD    = STATE_W'(1) << 38,
        ST_EM_OUT   = STATE_W'(1) << 39,
        ST_SING     = STATE_W'(1) << 40
    } state_t;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t              state_reg, state_next;
    logic [3:0]          size_reg;
    logic [CNT_W-1:0]    lrow_reg, lrow_next;
    logic [CNT_W-1:0]    lcol_reg, lcol_next;
    logic [CNT_W-1:0]    i_reg, i_next;
    logic [CNT_W-1:0]    j_reg, j_next;
    logic [CNT_W-1:0]    k_reg, k_next;
    logic [CNT_W-1:0]    c_reg, c_next;
    logic [31:0]         big_reg, big_next;
    logic signed [63:0]  s_reg, s_next;
    logic signed [31:0]  a_reg, a_next;
    logic signed [31:0]  v_reg, v_next;
    logic signed [31:0]  piv_reg, piv_next;
    logic signed [31:0]  t_reg, t_next;
    logic [63:0]         best_reg, best_next;
    logic [IDX_W-1:0]    imax_reg, imax_next;
    logic signed [65:0]  prod_reg;
    logic                div_neg_reg, div_neg_next;
    logic                div_scale_reg, div_scale_next;
    logic                out_valid_reg, out_valid_next;
    logic signed [31:0]  out_value_reg, out_value_next;
    logic                out_status_reg, out_status_next;
    logic                out_last_reg, out_last_next;
    logic [31:0]         row_scale_reg [MAX_SIZE];
    logic [IDX_W-1:0]    pivot_rows_reg [MAX_SIZE];

    // ------------------------------------------------------------------
    // Combinational signals
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]    n_eff;
    logic [IDX_W-1:0]    i_idx, j_idx, k_idx, lrow_idx, lcol_idx;
    logic                i_last, j_last, k_last, c_last, lrow_last, lcol_last;
    logic [CNT_W-1:0]    cl_limit;
    logic                cfg_wr;
    logic                in_xfer;
    logic                out_free;

    logic                m_we;
    logic [MAT_AW-1:0]   m_waddr, m_raddr;
    logic [31:0]         m_wdata, m_rdata;
    logic                cw_we;
    logic [IDX_W-1:0]    cw_waddr, cw_raddr;
    logic [31:0]         cw_wdata, cw_rdata;

    logic                rs_we;
    logic [IDX_W-1:0]    rs_widx, rs_ridx;
    logic [31:0]         rs_wdata, rs_rd;
    logic                pr_we;
    logic [IDX_W-1:0]    pr_rd;

    logic signed [32:0]  mul_a, mul_b;
    logic signed [65:0]  prod_shift;
    logic signed [63:0]  prod_sh;
    logic signed [63:0]  s_sub;
    logic [31:0]         big_new;
    logic                score_take;
    logic [IDX_W-1:0]    imax_new;

    div_req_t            div_req;
    div_rsp_t            div_rsp;
    logic signed [63:0]  dnum;
    logic signed [31:0]  dden;
    logic [63:0]         dnum_mag;
    logic [63:0]         dnum_clamp;
    logic [DIV_W-1:0]    q;
    logic [31:0]         q_sat;

    // Effective order: zero acts as one, large values clip to the maximum
    always_comb
    begin
        if (size_reg == 4'd0)
            n_eff = CNT_W'(1);
        else if (32'(size_reg) > MAX_SIZE)
            n_eff = CNT_W'(MAX_SIZE);
        else
            n_eff = CNT_W'(size_reg);
    end

    assign i_idx     = i_reg[IDX_W-1:0];
    assign j_idx     = j_reg[IDX_W-1:0];
    assign k_idx     = k_reg[IDX_W-1:0];
    assign lrow_idx  = lrow_reg[IDX_W-1:0];
    assign lcol_idx  = lcol_reg[IDX_W-1:0];
    assign i_last    = (CNT_W'(i_reg + 1'b1) == n_eff);
    assign j_last    = (CNT_W'(j_reg + 1'b1) == n_eff);
    assign k_last    = (CNT_W'(k_reg + 1'b1) == n_eff);
    assign c_last    = (CNT_W'(c_reg + 1'b1) == n_eff);
    assign lrow_last = (CNT_W'(lrow_reg + 1'b1) == n_eff);
    assign lcol_last = (CNT_W'(lcol_reg + 1'b1) == n_eff);
    assign cl_limit  = (i_reg < j_reg) ? i_reg : j_reg;

    // Configuration port
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_MATRIX_SIZE);
    assign prdata   = (paddr[2] == REG_MATRIX_SIZE) ? {28'd0, size_reg} : 32'd0;

    // Handshakes
    assign in_stall = (state_reg != ST_LOAD);
    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Small register stores, one read port each
    assign rs_rd = row_scale_reg[rs_ridx];
    assign pr_rd = pivot_rows_reg[i_idx];

    // Product path
    assign prod_shift = prod_reg >>> FRAC_BITS;
    assign prod_sh    = $signed(prod_shift[63:0]);
    assign s_sub      = s_reg - prod_sh;

    // Row maximum and pivot score compare
    assign big_new    = (mag32(m_rdata) > big_reg) ? mag32(m_rdata) : big_reg;
    assign score_take = (prod_reg[63:0] >= best_reg);
    assign imax_new   = score_take ? i_idx : imax_reg;

    // Multiplier operand select
    always_comb
    begin
        unique case (state_reg)
            ST_CL_MUL:
            begin
                mul_a = 33'(a_reg);
                mul_b = 33'($signed(m_rdata));
            end
            ST_FW_MUL, ST_BK_MUL:
            begin
                mul_a = 33'($signed(m_rdata));
                mul_b = 33'($signed(cw_rdata));
            end
            ST_CL_SCM:
            begin
                mul_a = $signed({1'b0, rs_rd});
                mul_b = $signed({1'b0, mag32(v_reg)});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // Divider operands: clamp, scale by 2^F, divide magnitudes
    assign dnum       = (state_reg == ST_DV_START) ? ext64($signed(m_rdata)) : s_reg;
    assign dden       = (state_reg == ST_DV_START) ? piv_reg : $signed(m_rdata);
    assign dnum_mag   = dnum[63] ? 64'(-dnum) : 64'(dnum);
    assign dnum_clamp = (dnum_mag > NUM_LIM) ? NUM_LIM : dnum_mag;

    always_comb
    begin
        div_req.start   = 1'b0;
        div_req.num_mag = DIV_W'(dnum_clamp << FRAC_BITS);
        div_req.den_mag = mag32(dden);
        if (state_reg == ST_SC_CMP)
        begin
            div_req.start   = k_last && (big_new != 32'd0);
            div_req.num_mag = SCALE_NUM;
            div_req.den_mag = big_new;
        end
        else if (state_reg == ST_DV_START || state_reg == ST_BK_DST)
        begin
            div_req.start = 1'b1;
        end
    end

    luinv_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Quotient saturation: unsigned for row scales, signed otherwise
    assign q = div_rsp.quot;
    always_comb
    begin
        if (div_scale_reg)
            q_sat = (q > DIV_W'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : q[31:0];
        else if (div_neg_reg)
            q_sat = (q > DIV_W'(32'h80000000)) ? 32'h80000000 : 32'(-q[31:0]);
        else
            q_sat = (q > DIV_W'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : q[31:0];
    end

    // Memories
    luinv_ram #(.WIDTH(32), .DEPTH(MAT_DEPTH)) u_mat_ram (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

    luinv_ram #(.WIDTH(32), .DEPTH(MAX_SIZE)) u_cw_ram (
        .clk   (clk),
        .we    (cw_we),
        .waddr (cw_waddr),
        .wdata (cw_wdata),
        .raddr (cw_raddr),
        .rdata (cw_rdata)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        lrow_next       = lrow_reg;
        lcol_next       = lcol_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        c_next          = c_reg;
        big_next        = big_reg;
        s_next          = s_reg;
        a_next          = a_reg;
        v_next          = v_reg;
        piv_next        = piv_reg;
        t_next          = t_reg;
        best_next       = best_reg;
        imax_next       = imax_reg;
        div_neg_next    = div_neg_reg;
        div_scale_next  = div_scale_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_free ? 1'b0 : out_valid_reg;

        m_we     = 1'b0;
        m_waddr  = mat_addr(i_idx, j_idx);
        m_wdata  = sat32(s_reg);
        m_raddr  = mat_addr(i_idx, j_idx);
        cw_we    = 1'b0;
        cw_waddr = i_idx;
        cw_wdata = sat32(s_reg);
        cw_raddr = i_idx;
        rs_we    = 1'b0;
        rs_widx  = i_idx;
        rs_wdata = q_sat;
        rs_ridx  = i_idx;
        pr_we    = 1'b0;

        if (div_req.start)
        begin
            div_scale_next = (state_reg == ST_SC_CMP);
            div_neg_next   = dnum[63] ^ dden[31];
        end

        unique case (state_reg)
            // Element load, row-major
            ST_LOAD:
            begin
                m_waddr = mat_addr(lrow_idx, lcol_idx);
                m_wdata = element_value;
                if (in_xfer)
                begin
                    m_we = 1'b1;
                    if (lcol_last)
                    begin
                        lcol_next = '0;
                        if (lrow_last)
                        begin
                            lrow_next  = '0;
                            i_next     = '0;
                            k_next     = '0;
                            big_next   = '0;
                            state_next = ST_SC_RD;
                        end
                        else
                        begin
                            lrow_next = CNT_W'(lrow_reg + 1'b1);
                        end
                    end
                    else
                    begin
                        lcol_next = CNT_W'(lcol_reg + 1'b1);
                    end
                end
            end

            // Implicit row scaling
            ST_SC_RD:
            begin
                m_raddr    = mat_addr(i_idx, k_idx);
                state_next = ST_SC_CMP;
            end
            ST_SC_CMP:
            begin
                big_next = big_new;
                if (k_last)
                    state_next = (big_new == 32'd0) ? ST_SING : ST_SC_DIV;
                else
                begin
                    k_next     = CNT_W'(k_reg + 1'b1);
                    state_next = ST_SC_RD;
                end
            end
            ST_SC_DIV:
            begin
                if (div_rsp.done)
                begin
                    rs_we = 1'b1;
                    if (i_last)
                    begin
                        i_next     = '0;
                        j_next     = '0;
                        best_next  = '0;
                        imax_next  = '0;
                        state_next = ST_CL_RD0;
                    end
                    else
                    begin
                        i_next     = CNT_W'(i_reg + 1'b1);
                        k_next     = '0;
                        big_next   = '0;
                        state_next = ST_SC_RD;
                    end
                end
            end

            // Column j: reduce each entry by earlier products
            ST_CL_RD0:
            begin
                state_next = ST_CL_LD0;
            end
            ST_CL_LD0:
            begin
                s_next     = ext64($signed(m_rdata));
                k_next     = '0;
                state_next = (cl_limit == '0) ? ST_CL_WR : ST_CL_RDA;
            end
            ST_CL_RDA:
            begin
                m_raddr    = mat_addr(i_idx, k_idx);
                state_next = ST_CL_RDB;
            end
            ST_CL_RDB:
            begin
                a_next     = $signed(m_rdata);
                m_raddr    = mat_addr(k_idx, j_idx);
                state_next = ST_CL_MUL;
            end
            ST_CL_MUL:
            begin
                state_next = ST_CL_ACC;
            end
            ST_CL_ACC:
            begin
                s_next = s_sub;
                k_next = CNT_W'(k_reg + 1'b1);
                if (CNT_W'(k_reg + 1'b1) == cl_limit)
                    state_next = ST_CL_WR;
                else
                    state_next = ST_CL_RDA;
            end
            ST_CL_WR:
            begin
                m_we   = 1'b1;
                v_next = sat32(s_reg);
                if (i_reg >= j_reg)
                    state_next = ST_CL_SCM;
                else
                begin
                    i_next     = CNT_W'(i_reg + 1'b1);
                    state_next = ST_CL_RD0;
                end
            end
            ST_CL_SCM:
            begin
                state_next = ST_CL_SCC;
            end
            ST_CL_SCC:
            begin
                // last equal score wins
                imax_next = imax_new;
                if (score_take)
                    best_next = prod_reg[63:0];
                if (i_last)
                begin
                    pr_we   = 1'b1;
                    rs_ridx = j_idx;
                    k_next  = '0;
                    if (imax_new != j_idx)
                    begin
                        rs_we      = 1'b1;
                        rs_widx    = imax_new;
                        rs_wdata   = rs_rd;
                        state_next = ST_SW_RD1;
                    end
                    else
                    begin
                        state_next = ST_PV_RD;
                    end
                end
                else
                begin
                    i_next     = CNT_W'(i_reg + 1'b1);
                    state_next = ST_CL_RD0;
                end
            end

            // Row interchange, one column per pass
            ST_SW_RD1:
            begin
                m_raddr    = mat_addr(imax_reg, k_idx);
                state_next = ST_SW_RD2;
            end
            ST_SW_RD2:
            begin
                t_next     = $signed(m_rdata);
                m_raddr    = mat_addr(j_idx, k_idx);
                state_next = ST_SW_WR1;
            end
            ST_SW_WR1:
            begin
                m_we       = 1'b1;
                m_waddr    = mat_addr(imax_reg, k_idx);
                m_wdata    = m_rdata;
                state_next = ST_SW_WR2;
            end
            ST_SW_WR2:
            begin
                m_we    = 1'b1;
                m_waddr = mat_addr(j_idx, k_idx);
                m_wdata = t_reg;
                if (k_last)
                    state_next = ST_PV_RD;
                else
                begin
                    k_next     = CNT_W'(k_reg + 1'b1);
                    state_next = ST_SW_RD1;
                end
            end

            // Pivot check and division of the lower column
            ST_PV_RD:
            begin
                m_raddr    = mat_addr(j_idx, j_idx);
                state_next = ST_PV_CHK;
            end
            ST_PV_CHK:
            begin
                piv_next = $signed(m_rdata);
                if (m_rdata == 32'd0)
                    state_next = ST_SING;
                else if (j_last)
                begin
                    c_next     = '0;
                    i_next     = '0;
                    state_next = ST_CW_INIT;
                end
                else
                begin
                    i_next     = CNT_W'(j_reg + 1'b1);
                    state_next = ST_DV_RD;
                end
            end
            ST_DV_RD:
            begin
                state_next = ST_DV_START;
            end
            ST_DV_START:
            begin
                state_next = ST_DV_WAIT;
            end
            ST_DV_WAIT:
            begin
                m_wdata = q_sat;
                if (div_rsp.done)
                begin
                    m_we = 1'b1;
                    if (i_last)
                    begin
                        j_next     = CNT_W'(j_reg + 1'b1);
                        i_next     = '0;
                        best_next  = '0;
                        imax_next  = IDX_W'(j_reg + 1'b1);
                        state_next = ST_CL_RD0;
                    end
                    else
                    begin
                        i_next     = CNT_W'(i_reg + 1'b1);
                        state_next = ST_DV_RD;
                    end
                end
            end

            // Unit column c
            ST_CW_INIT:
            begin
                cw_we    = 1'b1;
                cw_wdata = (i_reg == c_reg) ? ONE_FX : 32'd0;
                if (i_last)
                begin
                    i_next     = '0;
                    state_next = ST_FW_RD;
                end
                else
                begin
                    i_next = CNT_W'(i_reg + 1'b1);
                end
            end

            // Forward substitution with row permutation
            ST_FW_RD:
            begin
                cw_raddr   = pr_rd;
                state_next = ST_FW_RD2;
            end
            ST_FW_RD2:
            begin
                s_next     = ext64($signed(cw_rdata));
                state_next = ST_FW_WR;
            end
            ST_FW_WR:
            begin
                cw_we      = 1'b1;
                cw_waddr   = pr_rd;
                cw_wdata   = cw_rdata;
                k_next     = '0;
                state_next = (i_reg == '0) ? ST_FW_ST : ST_FW_RDA;
            end
            ST_FW_RDA:
            begin
                m_raddr    = mat_addr(i_idx, k_idx);
                cw_raddr   = k_idx;
                state_next = ST_FW_MUL;
            end
            ST_FW_MUL:
            begin
                state_next = ST_FW_ACC;
            end
            ST_FW_ACC:
            begin
                s_next = s_sub;
                k_next = CNT_W'(k_reg + 1'b1);
                if (CNT_W'(k_reg + 1'b1) == i_reg)
                    state_next = ST_FW_ST;
                else
                    state_next = ST_FW_RDA;
            end
            ST_FW_ST:
            begin
                cw_we = 1'b1;
                if (i_last)
                    state_next = ST_BK_RD;
                else
                begin
                    i_next     = CNT_W'(i_reg + 1'b1);
                    state_next = ST_FW_RD;
                end
            end

            // Back substitution, bottom row first
            ST_BK_RD:
            begin
                state_next = ST_BK_LD;
            end
            ST_BK_LD:
            begin
                s_next     = ext64($signed(cw_rdata));
                k_next     = CNT_W'(i_reg + 1'b1);
                state_next = i_last ? ST_BK_DRD : ST_BK_RDA;
            end
            ST_BK_RDA:
            begin
                m_raddr    = mat_addr(i_idx, k_idx);
                cw_raddr   = k_idx;
                state_next = ST_BK_MUL;
            end
            ST_BK_MUL:
            begin
                state_next = ST_BK_ACC;
            end
            ST_BK_ACC:
            begin
                s_next = s_sub;
                if (k_last)
                    state_next = ST_BK_DRD;
                else
                begin
                    k_next     = CNT_W'(k_reg + 1'b1);
                    state_next = ST_BK_RDA;
                end
            end
            ST_BK_DRD:
            begin
                m_raddr    = mat_addr(i_idx, i_idx);
                state_next = ST_BK_DST;
            end
            ST_BK_DST:
            begin
                state_next = ST_BK_DW;
            end
            ST_BK_DW:
            begin
                cw_wdata = q_sat;
                if (div_rsp.done)
                begin
                    cw_we = 1'b1;
                    if (i_reg == '0)
                        state_next = ST_EM_RD;
                    else
                    begin
                        i_next     = CNT_W'(i_reg - 1'b1);
                        state_next = ST_BK_RD;
                    end
                end
            end

            // Stream the solved column
            ST_EM_RD:
            begin
                state_next = ST_EM_OUT;
            end
            ST_EM_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = $signed(cw_rdata);
                    out_status_next = 1'b0;
                    out_last_next   = c_last && i_last;
                    if (i_last)
                    begin
                        i_next = '0;
                        if (c_last)
                            state_next = ST_LOAD;
                        else
                        begin
                            c_next     = CNT_W'(c_reg + 1'b1);
                            state_next = ST_CW_INIT;
                        end
                    end
                    else
                    begin
                        i_next     = CNT_W'(i_reg + 1'b1);
                        state_next = ST_EM_RD;
                    end
                end
            end

            // Singular result
            ST_SING:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = '0;
                    out_status_next = 1'b1;
                    out_last_next   = 1'b1;
                    state_next      = ST_LOAD;
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        // A size write restarts loading
        if (cfg_wr)
        begin
            lrow_next = '0;
            lcol_next = '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            size_reg      <= 4'd8;
            lrow_reg      <= '0;
            lcol_reg      <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            c_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lrow_reg      <= lrow_next;
            lcol_reg      <= lcol_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            c_reg         <= c_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr)
                size_reg <= pwdata[3:0];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        big_reg        <= big_next;
        s_reg          <= s_next;
        a_reg          <= a_next;
        v_reg          <= v_next;
        piv_reg        <= piv_next;
        t_reg          <= t_next;
        best_reg       <= best_next;
        imax_reg       <= imax_next;
        div_neg_reg    <= div_neg_next;
        div_scale_reg  <= div_scale_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
        if (rs_we)
            row_scale_reg[rs_widx] <= rs_wdata;
        if (pr_we)
            pivot_rows_reg[j_idx] <= imax_new;
    end

    assign out_valid     = out_valid_reg;
    assign inverse_value = out_value_reg;
    assign status        = out_status_reg;
    assign last_result   = out_last_reg;

endmodule

// ===== hdl/luinv_checker.sv =====
// ----------------------------------------------------------------------------
// luinv_checker
// Port-level checks on the result stream of the LU matrix inverse.
// ----------------------------------------------------------------------------
module luinv_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] inverse_value,
    input logic        status,
    input logic        last_result
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(inverse_value)
                                  && $stable(status) && $stable(last_result))
        else $error("stalled result changed");

    // A singular report is the only and last result of its run
    a_sing_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> last_result)
        else $error("singular result not marked last");

    // A singular report carries a zero value
    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> inverse_value == 32'd0)
        else $error("singular result with nonzero value");

    // No loading while a run is still streaming its columns
    a_no_load_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_result |-> in_stall)
        else $error("input taken in the middle of a result stream");

endmodule

bind lu_pivot_matrix_inverse_core luinv_checker u_luinv_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .inverse_value (inverse_value),
    .status        (status),
    .last_result   (last_result)
);

// ===== tb/tb_lu_pivot_matrix_inverse_core.sv =====
// ----------------------------------------------------------------------------
// tb_lu_pivot_matrix_inverse_core
// Self-checking bench for the LU matrix inverse core. Matrices are loaded
// through the element stream, and the streamed inverse is compared against a
// fixed-point LU predictor held in the bench. A directed table covers the
// extremes, the size clamping, the bad register index, a restart in the middle
// of a load, and the singular cases. Random matrices follow under bursty input
// and output back-pressure.
// ----------------------------------------------------------------------------
module tb_lu_pivot_matrix_inverse_core;
    import luinv_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [31:0] q_t;

    typedef struct {
        q_t val;
        bit sing;
        bit last;
    } inv_word_t;

    typedef struct {
        int cfg_idx;        // -1: no register write before this transfer
        int cfg_val;
        q_t elem;
        bit known;          // expected value typed in below
        q_t exp_val;
        bit exp_sing;
    } vec_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    q_t          element_value = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    q_t          inverse_value;
    logic        status, last_result;

    lu_pivot_matrix_inverse_core dut (.*);

    always #1 clk = ~clk;

    // ---------------------------------------------------------------- predictor
    q_t          lu_mat[MAT_DEPTH];
    logic [31:0] lu_scale[MAX_SIZE];
    int          lu_perm[MAX_SIZE];
    q_t          lu_col[MAX_SIZE];
    int          elems_loaded = 0;
    int          size_reg = 8;

    inv_word_t   inv_expected[$];
    int          errors = 0;
    int          results_seen = 0;
    int          singular_seen = 0;
    int          items_sent = 0;
    int          matrices_sent = 0;

    function automatic q_t sat_q(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return q_t'(v);
    endfunction

    // product with floor rounding
    function automatic longint mul_q(q_t a, q_t b);
        longint p;
        p = longint'(a) * longint'(b);
        return p >>> FRAC_BITS;
    endfunction

    function automatic q_t div_q(longint num, q_t den);
        longint lim;
        lim = longint'(1) << (62 - FRAC_BITS);
        if (num > lim) num = lim;
        if (num < -lim) num = -lim;
        return sat_q((num * (longint'(1) << FRAC_BITS)) / longint'(den));
    endfunction

    function automatic logic [31:0] abs_q(q_t v);
        longint w;
        w = longint'(v);
        return (w < 0) ? 32'(-w) : 32'(w);
    endfunction

    function automatic int eff_size();
        if (size_reg == 0) return 1;
        if (size_reg > MAX_SIZE) return MAX_SIZE;
        return size_reg;
    endfunction

    // Crout LU with implicit scaling; returns 0 when singular
    function automatic bit lu_factor(int n);
        logic [31:0] big;
        longint unsigned r, best, score;
        longint s;
        int imax;
        q_t t, pv;
        for (int i = 0; i < n; i++) begin
            big = 0;
            for (int j = 0; j < n; j++)
                if (abs_q(lu_mat[i*MAX_SIZE+j]) > big) big = abs_q(lu_mat[i*MAX_SIZE+j]);
            if (big == 0) return 0;
            r = (64'd1 << (2*FRAC_BITS)) / big;
            lu_scale[i] = (r > 64'h7FFFFFFF) ? 32'h7FFFFFFF : r[31:0];
        end
        for (int j = 0; j < n; j++) begin
            best = 0;
            imax = j;
            for (int i = 0; i < j; i++) begin
                s = lu_mat[i*MAX_SIZE+j];
                for (int k = 0; k < i; k++)
                    s -= mul_q(lu_mat[i*MAX_SIZE+k], lu_mat[k*MAX_SIZE+j]);
                lu_mat[i*MAX_SIZE+j] = sat_q(s);
            end
            for (int i = j; i < n; i++) begin
                s = lu_mat[i*MAX_SIZE+j];
                for (int k = 0; k < j; k++)
                    s -= mul_q(lu_mat[i*MAX_SIZE+k], lu_mat[k*MAX_SIZE+j]);
                lu_mat[i*MAX_SIZE+j] = sat_q(s);
                score = longint'(lu_scale[i]) * longint'(abs_q(lu_mat[i*MAX_SIZE+j]));
                // ties go to the later row
                if (score >= best) begin
                    best = score;
                    imax = i;
                end
            end
            if (imax != j) begin
                for (int k = 0; k < n; k++) begin
                    t = lu_mat[imax*MAX_SIZE+k];
                    lu_mat[imax*MAX_SIZE+k] = lu_mat[j*MAX_SIZE+k];
                    lu_mat[j*MAX_SIZE+k] = t;
                end
                lu_scale[imax] = lu_scale[j];
            end
            lu_perm[j] = imax;
            pv = lu_mat[j*MAX_SIZE+j];
            if (pv == 0) return 0;
            for (int i = j + 1; i < n; i++)
                lu_mat[i*MAX_SIZE+j] = div_q(lu_mat[i*MAX_SIZE+j], pv);
        end
        return 1;
    endfunction

    // forward then back substitution on lu_col
    function automatic void lu_solve(int n);
        int ip;
        longint s;
        for (int i = 0; i < n; i++) begin
            ip = lu_perm[i];
            s = lu_col[ip];
            lu_col[ip] = lu_col[i];
            for (int j = 0; j < i; j++)
                s -= mul_q(lu_mat[i*MAX_SIZE+j], lu_col[j]);
            lu_col[i] = sat_q(s);
        end
        for (int i = n - 1; i >= 0; i--) begin
            s = lu_col[i];
            for (int j = i + 1; j < n; j++)
                s -= mul_q(lu_mat[i*MAX_SIZE+j], lu_col[j]);
            lu_col[i] = div_q(s, lu_mat[i*MAX_SIZE+i]);
        end
    endfunction

    // absorb one element; inverse words land in res[], count returned
    function automatic int load_element(q_t v, ref inv_word_t res[$]);
        int n, total;
        inv_word_t w;
        n = eff_size();
        total = n * n;
        res.delete();
        if (elems_loaded >= total) elems_loaded = 0;
        lu_mat[(elems_loaded / n)*MAX_SIZE + (elems_loaded % n)] = v;
        elems_loaded++;
        if (elems_loaded < total) return 0;
        elems_loaded = 0;
        if (!lu_factor(n)) begin
            w.val = 0; w.sing = 1; w.last = 1;
            res.push_back(w);
            return 1;
        end
        for (int j = 0; j < n; j++) begin
            for (int i = 0; i < n; i++)
                lu_col[i] = (i == j) ? q_t'(ONE_FX) : 0;
            lu_solve(n);
            for (int i = 0; i < n; i++) begin
                w.val = lu_col[i];
                w.sing = 0;
                w.last = (j*n + i == total - 1);
                res.push_back(w);
            end
        end
        return total;
    endfunction

    // ---------------------------------------------------------------- drivers
    int  burst_left = 4;
    bit  hold_go = 0;
    int  hold_cnt = 0;
    int  stall_phase = 0;
    int  stall_mode = 0;

    // one element transfer, followed by a random gap at burst end
    task automatic send_element(q_t v, bit known = 0, q_t exp_val = 0, bit exp_sing = 0);
        inv_word_t res[$];
        inv_word_t w;
        in_valid <= 1'b1;
        element_value <= v;
        do @(posedge clk); while (in_stall);
        items_sent++;
        if (load_element(v, res) > 0) begin
            matrices_sent++;
            if (known) begin
                w.val = exp_val; w.sing = exp_sing; w.last = 1;
                inv_expected.push_back(w);
            end else begin
                foreach (res[i]) inv_expected.push_back(res[i]);
            end
        end
        burst_left--;
        if (burst_left <= 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
        end
    endtask

    // block drained, plus slack for a partial load still in flight
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (inv_expected.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic reg_write(int idx, int val);
        wait_idle();
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= 3'(4 * idx);
        pwdata <= 32'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == int'(REG_MATRIX_SIZE)) begin
            size_reg = val & 15;
            elems_loaded = 0;
        end
    endtask

    function automatic q_t rand_elem();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8) return 0;
        if (pick < 12) return ($urandom_range(0, 1)) ? 32'sh7FFFFFFF : 32'sh80000000;
        if (pick < 24) return q_t'($urandom);
        return q_t'($urandom_range(0, 32'h80000)) - 32'sh40000;
    endfunction

    task automatic send_matrix(int n);
        int zrow;
        zrow = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : -1;
        for (int i = 0; i < n*n; i++)
            send_element((i / n == zrow) ? 0 : rand_elem());
    endtask

    // ---------------------------------------------------------------- receiver
    always @(posedge clk) begin
        if (hold_cnt > 0) begin
            out_stall <= 1'b1;
            hold_cnt <= hold_cnt - 1;
        end else if (hold_go) begin
            out_stall <= 1'b1;
            hold_go <= 0;
            hold_cnt <= 3000;
        end else begin
            stall_phase <= stall_phase + 1;
            if (stall_phase % 50 == 0) stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // ---------------------------------------------------------------- checker
    always @(posedge clk) begin
        inv_word_t w;
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (status) singular_seen++;
            if (inv_expected.size() == 0) begin
                errors++;
                $display("%0t: expected no result, actual value=%h status=%b last=%b",
                         $time, inverse_value, status, last_result);
            end else begin
                w = inv_expected.pop_front();
                if (inverse_value !== w.val || status !== w.sing || last_result !== w.last) begin
                    errors++;
                    $display("%0t: mismatch expected value=%h status=%b last=%b, actual value=%h status=%b last=%b",
                             $time, w.val, w.sing, w.last, inverse_value, status,
                             last_result);
                end
            end
        end
    end

    // ---------------------------------------------------------------- stimulus
    vec_row_t vec_table[] = '{
        '{0, 1,  32'sh00000000, 1, 32'sh00000000,      1},  // zero 1x1 is singular
        '{-1, 0, 32'sh00010000, 1, 32'sh00010000,      0},  // 1.0
        '{-1, 0, 32'sh7FFFFFFF, 1, 32'sh00000002,      0},  // largest positive
        '{-1, 0, 32'sh80000000, 1, -32'sh00000002,     0},  // most negative
        '{-1, 0, 32'sh00000001, 1, 32'sh7FFFFFFF,      0},  // saturates high
        '{-1, 0, -32'sh00000001, 1, 32'sh80000000,     0},  // saturates low
        '{0, 0,  32'sh00020000, 1, 32'sh00008000,      0},  // size 0 acts as 1
        '{1, 5,  32'sh00030000, 0, 0, 0},                   // bad index ignored
        '{0, 2,  32'sh00000007, 0, 0, 0},                   // partial load
        '{-1, 0, 32'sh00000009, 0, 0, 0},
        '{-1, 0, 32'sh0000000B, 0, 0, 0},
        '{0, 2,  32'sh00000000, 0, 0, 0},                   // restart: swap matrix
        '{-1, 0, 32'sh00010000, 0, 0, 0},
        '{-1, 0, 32'sh00010000, 0, 0, 0},
        '{-1, 0, 32'sh00000000, 0, 0, 0},
        '{-1, 0, 32'sh00010000, 0, 0, 0},                   // zero second row
        '{-1, 0, 32'sh00020000, 0, 0, 0},
        '{-1, 0, 32'sh00000000, 0, 0, 0},
        '{-1, 0, 32'sh00000000, 1, 32'sh00000000,      1},
        '{-1, 0, 32'sh00010000, 0, 0, 0},                   // equal rows: zero pivot
        '{-1, 0, 32'sh00010000, 0, 0, 0},
        '{-1, 0, 32'sh00010000, 0, 0, 0},
        '{-1, 0, 32'sh00010000, 1, 32'sh00000000,      1}
    };

    initial begin
        int n;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (vec_table[r]) begin
            if (vec_table[r].cfg_idx >= 0)
                reg_write(vec_table[r].cfg_idx, vec_table[r].cfg_val);
            send_element(vec_table[r].elem, vec_table[r].known,
                         vec_table[r].exp_val, vec_table[r].exp_sing);
        end

        // one full-size matrix, size written above the top of the range
        reg_write(int'(REG_MATRIX_SIZE), 15);
        send_matrix(8);

        // long output hold-off while small matrices keep coming
        reg_write(int'(REG_MATRIX_SIZE), 2);
        hold_go <= 1;
        repeat (5) send_matrix(2);

        // random sizes, mostly small
        while (items_sent < 120) begin
            n = $urandom_range(1, 4);
            if ($urandom_range(0, 9) == 0) n = 5;
            reg_write(int'(REG_MATRIX_SIZE), (n == 1 && $urandom_range(0, 1)) ? 0 : n);
            send_matrix(n);
        end
        reg_write(int'(REG_MATRIX_SIZE), 8);

        wait_idle();
        repeat (100) @(posedge clk);
        $display("Sent %0d elements forming %0d matrices of order 1 to 8.",
                 items_sent, matrices_sent);
        $display("Checked %0d inverse words, %0d singular reports.",
                 results_seen, singular_seen);
        if (errors == 0 && inv_expected.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // watchdog
    initial begin
        #4000000;
        $display("Timeout with %0d words still expected.", inv_expected.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
